// File: design/sawlc_pkg.sv
// ----------------------------------------------------------------------------
// sawlc_pkg
// Types and constants for the set-associative write-back LRU cache.
// ----------------------------------------------------------------------------
package sawlc_pkg;

  localparam int unsigned DefBlockBytes = 16;
  localparam int unsigned DefWays       = 2;
  localparam int unsigned DefSets       = 8;
  localparam int unsigned DefMemBlocks  = 512;
  localparam int unsigned AddrW         = 13;
  localparam int unsigned WordW         = 32;

  typedef enum logic {
    FUNC_READ  = 1'b0,
    FUNC_WRITE = 1'b1
  } func_e;

  typedef struct packed {
    logic               func;
    logic [AddrW-1:0]   address;
    logic signed [31:0] write_data;
  } req_t;

  typedef struct packed {
    logic               hit;
    logic               wrote_back;
    logic               fetched;
    logic signed [31:0] read_data;
    logic [31:0]        hit_total;
    logic [31:0]        miss_total;
    logic [31:0]        mem_access_total;
  } rsp_t;

endpackage

// File: design/sawlc_ram.sv
// ----------------------------------------------------------------------------
// sawlc_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module sawlc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

// File: design/set_assoc_writeback_lru_cache.sv
// ----------------------------------------------------------------------------
// set_assoc_writeback_lru_cache
// Set-associative write-back, write-allocate cache with LRU replacement
// and a backing block store held in on-chip RAM.
// ----------------------------------------------------------------------------
// One item at a time. Line words and the backing store each sit in a
// single-port RAM; the tag array (valid, dirty, tag, stamp per line) is held
// in flip-flops. After reset the backing RAM is cleared one word per cycle,
// while no item is taken. A hit passes through the lookup, finish and
// readout states before its result is presented. A miss adds a copy of the
// block, one RAM word at a time, for a write-back of a dirty victim and again
// for the fill (none for a write miss with one-word blocks), each word read
// and then written. The input stays stalled until the result is taken, and
// the next item can be taken in the cycle after that.
// ----------------------------------------------------------------------------
module set_assoc_writeback_lru_cache
  import sawlc_pkg::*;
#(
  parameter int unsigned BLOCK_BYTES = DefBlockBytes,
  parameter int unsigned WAYS        = DefWays,
  parameter int unsigned SETS        = DefSets,
  parameter int unsigned MEM_BLOCKS  = DefMemBlocks
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  req_t in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output rsp_t out_data_o
);

  localparam int unsigned Wpb    = BLOCK_BYTES / 4;
  localparam int unsigned Lines  = WAYS * SETS;
  localparam int unsigned WoW    = (Wpb > 1) ? $clog2(Wpb) : 1;
  localparam int unsigned SetW   = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int unsigned WayW   = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int unsigned LineW  = (Lines > 1) ? $clog2(Lines) : 1;
  localparam int unsigned BlkW   = $clog2(MEM_BLOCKS);
  localparam int unsigned TagW   = (MEM_BLOCKS / SETS > 1) ? $clog2(MEM_BLOCKS / SETS) : 1;
  localparam int unsigned CDepth = Lines * Wpb;
  localparam int unsigned CAW    = $clog2(CDepth);
  localparam int unsigned MDepth = MEM_BLOCKS * Wpb;
  localparam int unsigned MAW    = $clog2(MDepth);
  localparam int unsigned WoCW   = $clog2(Wpb + 1);

  typedef enum logic [8:0] {
    ST_CLEAR = 9'b000000001,
    ST_IDLE  = 9'b000000010,
    ST_LOOK  = 9'b000000100,
    ST_WBRD  = 9'b000001000,
    ST_WBWR  = 9'b000010000,
    ST_FLRD  = 9'b000100000,
    ST_FLWR  = 9'b001000000,
    ST_FIN   = 9'b010000000,
    ST_RDOUT = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic [Lines-1:0]    valid_q, dirty_q;
  logic [TagW-1:0]     tag_q   [Lines];
  logic [31:0]         stamp_q [Lines];
  logic [31:0] acc_q, hit_q, miss_q, mem_q;
  logic [MAW-1:0]      clr_q;
  logic [WoCW-1:0]     cnt_q;
  req_t                req_q;
  logic [LineW-1:0]    line_q;
  logic [TagW-1:0]     vtag_q;
  logic                hit_r, wb_r, fe_r;
  logic                out_valid_q;
  rsp_t                out_q;

  // request decode
  logic [BlkW-1:0] blk;
  logic [WoW-1:0]  wo;
  logic [SetW-1:0] set_idx;
  logic [TagW-1:0] tag_v;
  assign blk     = BlkW'(({19'd0, req_q.address} / BLOCK_BYTES) % MEM_BLOCKS);
  assign wo      = WoW'(({19'd0, req_q.address} >> 2) % Wpb);
  assign set_idx = SetW'(32'(blk) % SETS);
  assign tag_v   = TagW'(32'(blk) / SETS);

  // way lookup and victim choice
  logic            found, have_free;
  logic [WayW-1:0] hway, fway, vway;
  always_comb begin
    logic [LineW-1:0] l;
    logic [LineW-1:0] b;
    found = 1'b0; have_free = 1'b0;
    hway = '0; fway = '0; vway = '0;
    b = LineW'(32'(set_idx) * WAYS);
    for (int w = WAYS - 1; w >= 0; w--) begin
      l = b + LineW'(w);
      if (valid_q[l] && tag_q[l] == tag_v) begin
        found = 1'b1; hway = WayW'(w);
      end
      if (!valid_q[l]) begin
        have_free = 1'b1; fway = WayW'(w);
      end
    end
    for (int w = 1; w < WAYS; w++) begin
      l = b + LineW'(w);
      if (stamp_q[l] < stamp_q[b + LineW'(vway)]) vway = WayW'(w);
    end
  end

  logic [LineW-1:0] sel_line;
  assign sel_line = LineW'(32'(set_idx) * WAYS) +
                    LineW'(found ? hway : (have_free ? fway : vway));

  logic wb_v, fe_v;
  assign wb_v = !found && !have_free && dirty_q[sel_line];
  assign fe_v = !found && (req_q.func == FUNC_READ || Wpb != 1);

  // RAMs
  logic            c_we, m_we;
  logic [CAW-1:0]  c_addr;
  logic [MAW-1:0]  m_addr;
  logic [31:0]     c_wd, c_rd, m_wd, m_rd;
  logic [WoW-1:0]  cw;
  logic [BlkW-1:0] vblk;
  assign cw   = WoW'(cnt_q);
  assign vblk = BlkW'((32'(vtag_q) * SETS + 32'(set_idx)) % MEM_BLOCKS);

  always_comb begin
    c_we = 1'b0; m_we = 1'b0;
    c_addr = CAW'(32'(line_q) * Wpb + 32'(wo));
    m_addr = MAW'(32'(blk) * Wpb + 32'(cw));
    c_wd = req_q.write_data; m_wd = c_rd;
    unique case (state_q)
      ST_CLEAR: begin
        m_we = 1'b1; m_addr = clr_q; m_wd = '0;
      end
      ST_WBRD: c_addr = CAW'(32'(line_q) * Wpb + 32'(cw));
      ST_WBWR: begin
        m_we = 1'b1; m_addr = MAW'(32'(vblk) * Wpb + 32'(cw));
      end
      ST_FLWR: begin
        c_we = 1'b1; c_addr = CAW'(32'(line_q) * Wpb + 32'(cw)); c_wd = m_rd;
      end
      ST_FIN: c_we = req_q.func == FUNC_WRITE;
      default: ;
    endcase
  end

  sawlc_ram #(.Width(32), .Depth(CDepth)) u_lines (
    .clk_i, .we_i(c_we), .addr_i(c_addr), .wdata_i(c_wd), .rdata_o(c_rd));
  sawlc_ram #(.Width(32), .Depth(MDepth)) u_store (
    .clk_i, .we_i(m_we), .addr_i(m_addr), .wdata_i(m_wd), .rdata_o(m_rd));

  assign in_stall_o  = (state_q != ST_IDLE) || out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  logic last;
  assign last = cnt_q == WoCW'(Wpb - 1);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_q == MAW'(MDepth - 1)) state_d = ST_IDLE;
      ST_IDLE:  if (in_valid_i && !in_stall_o) state_d = ST_LOOK;
      ST_LOOK: begin
        if (found) state_d = ST_FIN;
        else if (!have_free && dirty_q[sel_line]) state_d = ST_WBRD;
        else if (req_q.func == FUNC_READ || Wpb != 1) state_d = ST_FLRD;
        else state_d = ST_FIN;
      end
      ST_WBRD: state_d = ST_WBWR;
      ST_WBWR: begin
        if (!last) state_d = ST_WBRD;
        else if (req_q.func == FUNC_READ || Wpb != 1) state_d = ST_FLRD;
        else state_d = ST_FIN;
      end
      ST_FLRD: state_d = ST_FLWR;
      ST_FLWR: state_d = last ? ST_FIN : ST_FLRD;
      ST_FIN:  state_d = ST_RDOUT;
      ST_RDOUT: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0; cnt_q <= '0;
      valid_q <= '0; dirty_q <= '0;
      for (int i = 0; i < Lines; i++) begin
        tag_q[i] <= '0; stamp_q[i] <= '0;
      end
      acc_q <= '0; hit_q <= '0; miss_q <= '0; mem_q <= '0;
      out_valid_q <= 1'b0;
      hit_r <= 1'b0; wb_r <= 1'b0; fe_r <= 1'b0;
      line_q <= '0; vtag_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && !out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: clr_q <= clr_q + 1'b1;
        ST_IDLE: if (in_valid_i && !in_stall_o) acc_q <= acc_q + 1'b1;
        ST_LOOK: begin
          line_q <= sel_line; vtag_q <= tag_q[sel_line];
          cnt_q <= '0;
          hit_r <= found; wb_r <= wb_v; fe_r <= fe_v;
          if (found) hit_q <= hit_q + 1'b1;
          else miss_q <= miss_q + 1'b1;
          mem_q <= mem_q + 32'(wb_v) + 32'(fe_v);
        end
        ST_WBWR: cnt_q <= last ? '0 : cnt_q + 1'b1;
        ST_FLWR: cnt_q <= cnt_q + 1'b1;
        ST_FIN: begin
          valid_q[line_q] <= 1'b1;
          tag_q[line_q] <= tag_v;
          stamp_q[line_q] <= acc_q;
          if (req_q.func == FUNC_WRITE) dirty_q[line_q] <= 1'b1;
          else if (!hit_r) dirty_q[line_q] <= 1'b0;
        end
        ST_RDOUT: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && in_valid_i && !in_stall_o) req_q <= in_data_i;
    if (state_q == ST_RDOUT) begin
      out_q.hit <= hit_r;
      out_q.wrote_back <= wb_r;
      out_q.fetched <= fe_r;
      // the RAM returns the word from before the write in the last cycle
      out_q.read_data <= (req_q.func == FUNC_WRITE) ? req_q.write_data : c_rd;
      out_q.hit_total <= hit_q;
      out_q.miss_total <= miss_q;
      out_q.mem_access_total <= mem_q;
    end
  end

endmodule
